@@ design/pps_pkg.sv @@
package pps_pkg;

    // Width of candidate numbers and held primes
    localparam int VALUE_BITS = 16;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

    // Operation codes of an input transaction
    localparam logic OP_CAND  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [VALUE_BITS-1:0] candidate;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] prime_value;
        logic                  chain_full;
    } out_item_t;

    // Token that walks the chain, one cell per cycle
    typedef struct packed {
        logic valid;    // token present at this position
        logic alive;    // candidate not yet dropped or stored
        logic claimed;  // candidate stored in an empty cell
    } token_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic clear;    // empty the cell
        logic start;    // reset the remainder for a new candidate
        logic step;     // one restoring remainder step
        logic dbit;     // candidate bit for this step, MSB first
    } cell_ctl_t;

endpackage

@@ design/pps_cell.sv @@
module pps_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pps_pkg::cell_ctl_t                ctl,
    input  logic [pps_pkg::VALUE_BITS-1:0]    cand,
    input  pps_pkg::token_t                   tok_in,
    output pps_pkg::token_t                   tok_out,
    output logic                              used
);
    import pps_pkg::*;

    logic [VALUE_BITS-1:0] prime_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic                  used_reg;
    logic                  used_next;
    token_t                tok_reg;
    token_t                tok_next;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   diff;

    // One restoring step: shift in the next candidate bit, subtract if it fits
    always_comb begin
        shifted = {rem_reg, ctl.dbit};
        diff    = shifted - {1'b0, prime_reg};
        if (shifted >= {1'b0, prime_reg}) begin
            rem_next = diff[VALUE_BITS-1:0];
        end else begin
            rem_next = shifted[VALUE_BITS-1:0];
        end
    end

    // Resolve the token here: claim an empty cell or drop on a zero remainder
    always_comb begin
        tok_next  = tok_in;
        used_next = used_reg;
        if (tok_in.valid && tok_in.alive) begin
            if (!used_reg) begin
                tok_next.alive   = 1'b0;
                tok_next.claimed = 1'b1;
                used_next        = 1'b1;
            end else if (rem_reg == '0) begin
                tok_next.alive = 1'b0;
            end
        end
        if (ctl.clear) begin
            used_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    // Payload: remainder and held prime
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= '0;
        end else if (ctl.step) begin
            rem_reg <= rem_next;
        end
        if (tok_in.valid && tok_in.alive && !used_reg) begin
            prime_reg <= cand;
        end
    end

    assign tok_out = tok_reg;
    assign used    = used_reg;

endmodule

@@ design/pipelined_prime_sieve.sv @@
// Prime sieve built as a chain of filter cells, each holding one prime.
// Input channel s_valid/s_ready/s_data carries an op and a candidate.
// op = clear empties every cell in the accepting cycle and gives no result.
// A candidate below two is dropped on acceptance with no result.
// Any other candidate is fed MSB first to all cells at once, which build
// its remainder modulo their prime one bit per cycle.
// A token then walks the cell chain one cell per cycle: an occupied cell
// whose remainder is zero drops the candidate, the first empty cell stores
// it as a new prime. A survivor is reported on m_valid/m_ready/m_data;
// chain_full = 1 marks one that found no free cell and was not stored.
// From acceptance a candidate passes the remainder bit loop, the token
// injection, the chain walk and the result hand-off; the next transaction
// is taken only once all of that is done.
// Results sit in an output register; a stalled receiver blocks only the
// hand-off of the next result, the block waits until that register frees.
// Reset (aresetn low, synchronous) empties every cell and drops any
// transaction in flight.
module pipelined_prime_sieve #(
    parameter int NUM_CELLS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pps_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pps_pkg::out_item_t  m_data
);
    import pps_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_INJ  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [VALUE_BITS-1:0] cand_reg;
    logic [VALUE_BITS-1:0] shift_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    out_item_t             pend_reg;
    logic                  pend_valid_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    logic                  accept;
    logic                  is_start;
    logic                  out_free;
    cell_ctl_t             ctl;
    token_t                tok [0:NUM_CELLS];
    logic [NUM_CELLS-1:0]  used_vec;
    logic [NUM_CELLS-1:0]  tok_valid_vec;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_start = accept && (s_data.op == OP_CAND)
                      && (s_data.candidate[VALUE_BITS-1:1] != '0);
    assign out_free = !m_valid_reg || m_ready;

    // Broadcast control to the cells
    always_comb begin
        ctl.clear = accept && (s_data.op == OP_CLEAR);
        ctl.start = is_start;
        ctl.step  = (state_reg == ST_DIV);
        ctl.dbit  = shift_reg[VALUE_BITS-1];
    end

    // Inject a live token at the head of the chain
    assign tok[0] = '{valid: (state_reg == ST_INJ), alive: 1'b1, claimed: 1'b0};

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        pps_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .cand    (cand_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .used    (used_vec[i])
        );
        assign tok_valid_vec[i] = tok[i+1].valid;
    end

    // Sequence one candidate: remainder bits, token walk, result hand-off
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (is_start) state_next = ST_DIV;
            ST_DIV:  if (bit_cnt_reg == '0) state_next = ST_INJ;
            ST_INJ:  state_next = ST_SCAN;
            ST_SCAN: if (tok[NUM_CELLS].valid) state_next = ST_WAIT;
            ST_WAIT: if (!pend_valid_reg || out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Capture the outcome when the token leaves the last cell
            if (state_reg == ST_SCAN && tok[NUM_CELLS].valid) begin
                pend_valid_reg <= tok[NUM_CELLS].alive || tok[NUM_CELLS].claimed;
            end else if (state_reg == ST_WAIT && out_free) begin
                pend_valid_reg <= 1'b0;
            end
            // Output register: load a pending result, drop a taken one
            if (state_reg == ST_WAIT && pend_valid_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (is_start) begin
            cand_reg    <= s_data.candidate;
            shift_reg   <= s_data.candidate;
            bit_cnt_reg <= BIT_CNT_W'(VALUE_BITS - 1);
        end else if (state_reg == ST_DIV) begin
            shift_reg   <= {shift_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
        if (state_reg == ST_SCAN && tok[NUM_CELLS].valid) begin
            pend_reg.prime_value <= cand_reg;
            pend_reg.chain_full  <= tok[NUM_CELLS].alive;
        end
        if (state_reg == ST_WAIT && pend_valid_reg && out_free) begin
            m_data_reg <= pend_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // At most one token walks the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valid_vec))
        else $error("more than one token in the cell chain");

    // No token remains in the chain while new transactions are taken
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (tok_valid_vec == '0))
        else $error("token in the chain while idle");

    // Occupied cells always form a prefix of the chain
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((used_vec & (used_vec + 1'b1)) == '0))
        else $error("occupied cells do not form a prefix");

    // A clear empties every cell
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.op == OP_CLEAR) |=> (used_vec == '0))
        else $error("cells still occupied after clear");

endmodule

@@ sim/pipelined_prime_sieve_test.sv @@
module pipelined_prime_sieve_test;
    import pps_pkg::*;

    localparam int NUM_CELLS    = 64;
    localparam int DRAIN_CYCLES = VALUE_BITS + NUM_CELLS + 20;
    localparam int HOLD_CYCLES  = 800;
    localparam int MAX_GAP      = 60;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 60;

    typedef enum logic [1:0] {
        CHK_NONE,   // row must give no result
        CHK_TYPED,  // row gives the result typed in the table
        CHK_MODEL   // row is checked against the predictor
    } row_check_e;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } idle_phase_e;

    typedef struct packed {
        logic                  op;
        logic [VALUE_BITS-1:0] candidate;
        row_check_e            check;
        out_item_t             result;
    } directed_row_t;

    localparam int DIR_COUNT = 20;
    localparam directed_row_t DIR_ROWS [DIR_COUNT] = '{
        '{OP_CAND,  16'd2,     CHK_TYPED, '{16'd2,     1'b0}},
        '{OP_CAND,  16'd0,     CHK_NONE,  '{16'd0,     1'b0}},
        '{OP_CAND,  16'd1,     CHK_NONE,  '{16'd0,     1'b0}},
        '{OP_CAND,  16'd3,     CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CAND,  16'd4,     CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CAND,  16'd2,     CHK_NONE,  '{16'd0,     1'b0}},
        '{OP_CAND,  16'd65535, CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CAND,  16'd65521, CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CLEAR, 16'd0,     CHK_NONE,  '{16'd0,     1'b0}},
        '{OP_CAND,  16'd65535, CHK_TYPED, '{16'd65535, 1'b0}},
        '{OP_CAND,  16'd65535, CHK_NONE,  '{16'd0,     1'b0}},
        '{OP_CAND,  16'd32768, CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CAND,  16'd21845, CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CAND,  16'd43690, CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CLEAR, 16'd65535, CHK_NONE,  '{16'd0,     1'b0}},
        '{OP_CAND,  16'd1,     CHK_NONE,  '{16'd0,     1'b0}},
        '{OP_CAND,  16'd6,     CHK_TYPED, '{16'd6,     1'b0}},
        '{OP_CAND,  16'd9,     CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CAND,  16'd12,    CHK_MODEL, '{16'd0,     1'b0}},
        '{OP_CAND,  16'd35,    CHK_MODEL, '{16'd0,     1'b0}}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    // Predictor copy of the filter chain
    logic [VALUE_BITS-1:0] held_prime [NUM_CELLS];
    logic                  held_used  [NUM_CELLS];

    out_item_t   pending_primes [$];
    int          mismatches;
    int          items_sent;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    bit          hold_req;

    pipelined_prime_sieve #(
        .NUM_CELLS (NUM_CELLS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop a hung run
    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Pass one transaction through the chain; return 1 if it yields a prime report
    function automatic bit sieve_step(input in_item_t item, output out_item_t res);
        int i;
        res = '0;
        if (item.op == OP_CLEAR) begin
            for (i = 0; i < NUM_CELLS; i++) begin
                held_used[i]  = 1'b0;
                held_prime[i] = '0;
            end
            return 1'b0;
        end
        if (item.candidate < 2)
            return 1'b0;
        for (i = 0; i < NUM_CELLS; i++) begin
            // first empty cell takes the survivor as its prime
            if (!held_used[i]) begin
                held_used[i]    = 1'b1;
                held_prime[i]   = item.candidate;
                res.prime_value = item.candidate;
                res.chain_full  = 1'b0;
                return 1'b1;
            end
            if (item.candidate % held_prime[i] == 0)
                return 1'b0;
        end
        res.prime_value = item.candidate;
        res.chain_full  = 1'b1;
        return 1'b1;
    endfunction

    function automatic int unsigned draw_gap(input int unsigned pct);
        int unsigned n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < pct)
            n++;
        return n;
    endfunction

    function automatic void set_phase(input idle_phase_e ph);
        case (ph)
            PH_FREE: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            PH_SRC_IDLE: begin
                src_idle_pct  = 85;
                snk_stall_pct = 0;
            end
            PH_SNK_STALL: begin
                src_idle_pct  = 0;
                snk_stall_pct = 85;
            end
            default: begin
                src_idle_pct  = 37;
                snk_stall_pct = 37;
            end
        endcase
    endfunction

    // Offer one transaction at the falling edge and hold it until accepted
    task automatic put_item(input in_item_t item);
        int unsigned gap;
        gap = draw_gap(src_idle_pct);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Send a transaction and queue what the predictor says it yields
    task automatic feed(input logic op, input logic [VALUE_BITS-1:0] cand);
        in_item_t  item;
        out_item_t res;
        item.op        = op;
        item.candidate = cand;
        put_item(item);
        if (sieve_step(item, res))
            pending_primes.push_back(res);
        if (op == OP_CLEAR || cand >= 2) begin
            items_sent++;
            if (items_sent % PHASE_ITEMS == 0)
                set_phase(idle_phase_e'((items_sent / PHASE_ITEMS) % 4));
        end
    endtask

    // Drop valid after the last accepted transaction
    task automatic sender_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_primes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic noise_item();
        logic [VALUE_BITS-1:0] cand;
        cand = ($urandom_range(7) == 0) ? VALUE_BITS'($urandom_range(1)) : VALUE_BITS'($urandom);
        feed(($urandom_range(9) == 0) ? OP_CLEAR : OP_CAND, cand);
    endtask

    // Receiver ready: random stalls, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready  <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_primes.size() == 0) begin
                $error("unexpected result: prime_value=%0d chain_full=%0b",
                       m_data.prime_value, m_data.chain_full);
                mismatches++;
            end else begin
                want = pending_primes.pop_front();
                if (m_data.prime_value !== want.prime_value) begin
                    $error("prime_value: expected %0d, got %0d",
                           want.prime_value, m_data.prime_value);
                    mismatches++;
                end
                if (m_data.chain_full !== want.chain_full) begin
                    $error("chain_full: expected %0b, got %0b",
                           want.chain_full, m_data.chain_full);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        in_item_t    item;
        out_item_t   res;
        int          burst;
        int          seq_len;
        int          k;
        logic [VALUE_BITS-1:0] base;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        mismatches = 0;
        items_sent = 0;
        hold_req   = 1'b0;
        burst      = 0;
        set_phase(PH_FREE);
        for (k = 0; k < NUM_CELLS; k++) begin
            held_used[k]  = 1'b0;
            held_prime[k] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: typed rows push their own result, others use the predictor
        for (k = 0; k < DIR_COUNT; k++) begin
            item.op        = DIR_ROWS[k].op;
            item.candidate = DIR_ROWS[k].candidate;
            put_item(item);
            case (DIR_ROWS[k].check)
                CHK_MODEL: begin
                    if (sieve_step(item, res))
                        pending_primes.push_back(res);
                end
                CHK_TYPED: begin
                    void'(sieve_step(item, res));
                    pending_primes.push_back(DIR_ROWS[k].result);
                end
                default: begin
                    void'(sieve_step(item, res));
                end
            endcase
        end

        // Random part: mostly clear-and-count runs, some noise bursts
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (burst % 3 == 1)
                hold_req = 1'b1;
            if (burst % 3 == 2) begin
                sender_idle();
                wait_drained();
            end
            if ($urandom_range(3) != 0) begin
                seq_len = ($urandom_range(3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(300, 420);
                base = ($urandom_range(4) != 0) ? VALUE_BITS'(2)
                     : VALUE_BITS'($urandom_range(2, 65535 - seq_len));
                feed(OP_CLEAR, VALUE_BITS'($urandom));
                for (k = 0; k < seq_len && items_sent < RANDOM_ITEMS; k++) begin
                    if ($urandom_range(24) == 0)
                        noise_item();
                    feed(OP_CAND, base + VALUE_BITS'(k));
                end
            end else begin
                for (k = 0; k < 30; k++)
                    noise_item();
            end
            burst++;
        end

        // Drain and let the chain settle
        sender_idle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
